// ===== rtl/msr_pkg.sv =====
// ----------------------------------------------------------------------------
// msr_pkg
// Types, codes and helpers shared by the matrix slot palette resolver.
// ----------------------------------------------------------------------------
package msr_pkg;

	localparam int unsigned SLOT_COUNT_DEF  = 16;
	localparam int unsigned QUEUE_DEPTH_DEF = 2;
	localparam int unsigned PALETTE_W       = 17;
	localparam int unsigned INDEX_W         = 16;
	localparam int unsigned SLOT_FIELD_W    = 4;
	localparam int unsigned TOTAL_W         = 32;

	localparam logic [INDEX_W-1:0] REUSE_MARK = 16'hFFFF;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX  = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_EMPTY        = 3'd1,
		ST_SINGLE_REUSE = 3'd2,
		ST_RANGE        = 3'd3,
		ST_UNLOADED     = 3'd4
	} status_t;

	typedef struct packed {
		logic                    model_start;
		logic                    shape_start;
		logic                    multi_mode;
		logic [SLOT_FIELD_W-1:0] slot;
		logic [INDEX_W-1:0]      raw_index;
	} in_t;

	typedef struct packed {
		logic [INDEX_W-1:0] effective_index;
		status_t            status;
		logic               was_reused;
		logic [INDEX_W-1:0] max_index;
		logic               has_matrices;
		logic [TOTAL_W-1:0] loaded_total;
		logic [TOTAL_W-1:0] reused_total;
	} out_t;

	// entry as classified by the front end
	typedef struct packed {
		logic                    model_start;
		logic                    shape_start;
		logic                    multi_mode;
		logic [SLOT_FIELD_W-1:0] slot;
		logic [INDEX_W-1:0]      raw_index;
		logic                    is_reuse;
		logic                    in_range;
		logic                    empty;
	} cls_t;

	function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
		sat_inc = (v == TOTAL_MAX) ? v : v + TOTAL_W'(1);
	endfunction

endpackage

// ===== rtl/matrix_slot_palette_resolver.sv =====
// ----------------------------------------------------------------------------
// matrix_slot_palette_resolver
// Resolves matrix-table entries against per-slot draw matrix indices.
// ----------------------------------------------------------------------------
// One entry is taken per clock while in_stall is low, and one result is
// returned per entry, in order. An entry passes the front register, then one
// queue slot, then the output register before its result is valid on the
// output. The sustained rate of one entry per clock, when the output does not
// stall, is set by the back end, which does the slot table read-modify-write,
// error check, maximum and total updates together. A two-entry queue between
// front and back lets the input keep flowing for a while when the output is
// stalled. palette_size is written through the cfg channel, which is always
// ready; write it only while idle.
module matrix_slot_palette_resolver import msr_pkg::*; #(
	parameter int unsigned SLOT_COUNT  = SLOT_COUNT_DEF,
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_t                  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_t                 out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [PALETTE_W-1:0] cfg_data
);

	logic push;
	cls_t push_data;
	logic full;
	logic pop;
	cls_t pop_data;
	logic empty;

	msr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	msr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	msr_back #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.pop_data  (pop_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ===== rtl/msr_front.sv =====
// ----------------------------------------------------------------------------
// msr_front
// Input stage: holds the palette size register, classifies each entry
// (reuse mark, range check, empty palette) and hands it to the queue.
// ----------------------------------------------------------------------------
module msr_front import msr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_t                  in_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [PALETTE_W-1:0] cfg_data,
	output logic                 push,
	output cls_t                 push_data,
	input  logic                 full
);

	logic [PALETTE_W-1:0] palette_q;
	logic                 valid_s1;
	cls_t                 item_s1;
	cls_t                 cls_c;
	logic                 ready_c;
	logic                 accept_c;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			palette_q <= cfg_data;
		end
	end

	always_comb begin
		cls_c.model_start = in_data.model_start;
		cls_c.shape_start = in_data.shape_start;
		cls_c.multi_mode  = in_data.multi_mode;
		cls_c.slot        = in_data.slot;
		cls_c.raw_index   = in_data.raw_index;
		cls_c.is_reuse    = (in_data.raw_index == REUSE_MARK);
		cls_c.in_range    = ({1'b0, in_data.raw_index} < palette_q);
		cls_c.empty       = (palette_q == '0);
	end

	assign push     = valid_s1 && !full;
	assign ready_c  = !valid_s1 || !full;
	assign in_stall = !ready_c;
	assign accept_c = in_valid && ready_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_c) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_c) begin
			item_s1 <= cls_c;
		end
	end

	assign push_data = item_s1;

endmodule

// ===== rtl/msr_queue.sv =====
// ----------------------------------------------------------------------------
// msr_queue
// Short first-in first-out queue of classified entries between front and back.
// ----------------------------------------------------------------------------
module msr_queue import msr_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cls_t push_data,
	output logic full,
	input  logic pop,
	output cls_t pop_data,
	output logic empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	cls_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/msr_back.sv =====
// ----------------------------------------------------------------------------
// msr_back
// Resolve stage: slot table read-modify-write, sticky error, running maximum
// and saturating totals, with the registered result.
// ----------------------------------------------------------------------------
module msr_back import msr_pkg::*; #(
	parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic empty,
	input  cls_t pop_data,
	output logic pop,
	output logic out_valid,
	input  logic out_stall,
	output out_t out_data
);

	localparam int unsigned SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int unsigned EXT_W  = SLOT_W + SLOT_FIELD_W;
	localparam int unsigned CMP_W  = 8;

	logic [INDEX_W-1:0]  slot_value_q [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] slot_valid_q;
	logic [INDEX_W-1:0]  max_q;
	logic                any_q;
	logic [TOTAL_W-1:0]  load_q;
	logic [TOTAL_W-1:0]  reuse_q;
	status_t             sticky_q;
	logic                out_valid_q;
	out_t                out_q;

	logic                out_take;
	logic [EXT_W-1:0]    slot_ext;
	logic [SLOT_W-1:0]   idx;
	logic                slot_ok;
	logic [SLOT_COUNT-1:0] valid_base;
	logic [SLOT_COUNT-1:0] valid_c;
	status_t             sticky_base;
	logic [INDEX_W-1:0]  max_base;
	logic                any_base;
	logic [TOTAL_W-1:0]  load_base;
	logic [TOTAL_W-1:0]  reuse_base;
	status_t             status_c;
	logic [INDEX_W-1:0]  eff_c;
	logic                reused_c;
	logic                store_c;
	logic [INDEX_W-1:0]  max_c;
	logic                any_c;
	logic [TOTAL_W-1:0]  load_c;
	logic [TOTAL_W-1:0]  reuse_c;

	assign out_take  = !out_valid_q || !out_stall;
	assign pop       = !empty && out_take;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign slot_ext = EXT_W'(pop_data.slot);
	assign idx      = slot_ext[SLOT_W-1:0];
	assign slot_ok  = (CMP_W'(pop_data.slot) < CMP_W'(SLOT_COUNT));

	// a model start clears everything before the entry, a shape start the slot marks
	always_comb begin
		valid_base  = (pop_data.model_start || pop_data.shape_start) ? '0 : slot_valid_q;
		sticky_base = pop_data.model_start ? ST_OK : sticky_q;
		max_base    = pop_data.model_start ? '0 : max_q;
		any_base    = pop_data.model_start ? 1'b0 : any_q;
		load_base   = pop_data.model_start ? '0 : load_q;
		reuse_base  = pop_data.model_start ? '0 : reuse_q;
	end

	always_comb begin
		status_c = ST_OK;
		eff_c    = '0;
		reused_c = 1'b0;
		store_c  = 1'b0;
		if (sticky_base != ST_OK) begin
			status_c = sticky_base;
		end else if (pop_data.empty) begin
			status_c = ST_EMPTY;
		end else if (!pop_data.multi_mode) begin
			if (pop_data.is_reuse) begin
				status_c = ST_SINGLE_REUSE;
			end else if (!pop_data.in_range) begin
				status_c = ST_RANGE;
			end else begin
				eff_c = pop_data.raw_index;
			end
		end else if (pop_data.is_reuse) begin
			if (slot_ok && valid_base[idx]) begin
				eff_c    = slot_value_q[idx];
				reused_c = 1'b1;
			end else begin
				status_c = ST_UNLOADED;
			end
		end else if (!pop_data.in_range) begin
			status_c = ST_RANGE;
		end else begin
			eff_c   = pop_data.raw_index;
			store_c = slot_ok;
		end
	end

	always_comb begin
		valid_c = valid_base;
		if (store_c) begin
			valid_c[idx] = 1'b1;
		end
	end

	always_comb begin
		max_c   = max_base;
		any_c   = any_base;
		load_c  = load_base;
		reuse_c = reuse_base;
		if (status_c == ST_OK) begin
			if (reused_c) begin
				reuse_c = sat_inc(reuse_base);
			end else begin
				load_c = sat_inc(load_base);
			end
			if (!any_base || eff_c > max_base) begin
				max_c = eff_c;
			end
			any_c = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			max_q        <= '0;
			any_q        <= 1'b0;
			load_q       <= '0;
			reuse_q      <= '0;
			sticky_q     <= ST_OK;
			out_valid_q  <= 1'b0;
		end else begin
			out_valid_q <= pop || (out_valid_q && out_stall);
			if (pop) begin
				slot_valid_q <= valid_c;
				max_q        <= max_c;
				any_q        <= any_c;
				load_q       <= load_c;
				reuse_q      <= reuse_c;
				sticky_q     <= status_c;
			end
		end
	end

	// slot contents need no reset, the valid marks guard every read
	always_ff @(posedge clk) begin
		if (pop && store_c) begin
			slot_value_q[idx] <= pop_data.raw_index;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q.effective_index <= eff_c;
			out_q.status          <= status_c;
			out_q.was_reused      <= reused_c;
			out_q.max_index       <= max_c;
			out_q.has_matrices    <= any_c;
			out_q.loaded_total    <= load_c;
			out_q.reused_total    <= reuse_c;
		end
	end

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status != ST_OK |->
			out_q.effective_index == '0 && !out_q.was_reused)
		else $error("failing result carries an index or reuse mark");

	a_ok_resolved: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status == ST_OK |-> out_q.has_matrices)
		else $error("ok result without has_matrices");

	a_sticky_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !pop_data.model_start && sticky_q != ST_OK |=>
			sticky_q == $past(sticky_q))
		else $error("sticky error changed without a model start");

	a_sticky_out: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !pop_data.model_start && sticky_q != ST_OK |=>
			out_q.status == $past(sticky_q))
		else $error("result status differs from sticky error");

endmodule
